// File: sv/floppy_track_sector_extractor_assert.svh
// Assertion macros for the floppy track sector extractor.
// Expects clk and rst_n in the including scope.
`ifndef FLOPPY_TRACK_SECTOR_EXTRACTOR_ASSERT_SVH
`define FLOPPY_TRACK_SECTOR_EXTRACTOR_ASSERT_SVH

// same-cycle implication
`define FTSE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FTSE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/ftse_pkg.sv
// Shared types and constants of the floppy track sector extractor.
// No dependencies.
`default_nettype none

package ftse_pkg;

    localparam int RAW_W    = 8;
    localparam int OFFS_W   = 13;
    localparam int LEN_W    = 11;

    localparam logic [OFFS_W-1:0] DEST_BYTES = 13'd5120;

    localparam logic [RAW_W-1:0] BYTE_GAP   = 8'h4E;
    localparam logic [RAW_W-1:0] BYTE_SYNC  = 8'h00;
    localparam logic [RAW_W-1:0] BYTE_MARK  = 8'hA1;
    localparam logic [RAW_W-1:0] BYTE_IDAM  = 8'hFE;
    localparam logic [RAW_W-1:0] BYTE_DAM   = 8'hFB;

    localparam logic [RAW_W-1:0] SIZE_CODE_256  = 8'd1;
    localparam logic [RAW_W-1:0] SIZE_CODE_512  = 8'd2;
    localparam logic [RAW_W-1:0] SIZE_CODE_1024 = 8'd3;

    localparam logic [LEN_W-1:0] LEN_256  = 11'd256;
    localparam logic [LEN_W-1:0] LEN_512  = 11'd512;
    localparam logic [LEN_W-1:0] LEN_1024 = 11'd1024;

    typedef struct packed {
        logic [RAW_W-1:0] raw_byte;
        logic             track_end;
    } in_item_t;

    typedef struct packed {
        logic [RAW_W-1:0]  sector_byte;
        logic              byte_valid;
        logic [OFFS_W-1:0] dest_offset;
        logic              track_done;
        logic              track_ok;
    } result_t;

    typedef struct packed {
        logic    has;
        result_t res;
    } res_beat_t;

endpackage

`default_nettype wire

// File: sv/ftse_if.sv
// Valid/ready channel interfaces: raw track bytes in, sector results out.
// Depends on nothing but the port widths below.
`default_nettype none

interface ftse_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] raw_byte;
    logic       track_end;

    modport source (output valid, output raw_byte, output track_end, input ready);
    modport sink   (input valid, input raw_byte, input track_end, output ready);
endinterface

interface ftse_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  sector_byte;
    logic        byte_valid;
    logic [12:0] dest_offset;
    logic        track_done;
    logic        track_ok;

    modport source (output valid, output sector_byte, output byte_valid,
                    output dest_offset, output track_done, output track_ok,
                    input ready);
    modport sink   (input valid, input sector_byte, input byte_valid,
                    input dest_offset, input track_done, input track_ok,
                    output ready);
endinterface

`default_nettype wire

// File: sv/floppy_track_sector_extractor.sv
// Top level: input register, track parser, result register.
// Depends on ftse_pkg, ftse_if, ftse_parser, ftse_out_stage and the assert header.
//
//   channel     | dir | payload                                         | beat
//   track_in    | in  | raw_byte, track_end                             | one raw byte
//   sector_out  | out | sector_byte, byte_valid, dest_offset,           | data byte or
//               |     | track_done, track_ok                            | track verdict
//
// One byte per cycle unless stalled; results pass the input then the result register.
// The parser steps once per cycle on the registered byte; bytes with no result vanish.
// A stall on sector_out holds the parser only when the pending byte has a result.
// rst_n clears the parser to the gap phase and empties both registers.
`default_nettype none
`include "floppy_track_sector_extractor_assert.svh"

module floppy_track_sector_extractor
    import ftse_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    ftse_in_if.sink    track_in,
    ftse_out_if.source sector_out
);

    logic      in_vld_reg;
    in_item_t  in_item_reg;
    logic      proc;
    logic      can_take;
    res_beat_t beat;

    assign proc           = in_vld_reg && (!beat.has || can_take);
    assign track_in.ready = !in_vld_reg || proc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (track_in.valid && track_in.ready)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (proc)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (track_in.valid && track_in.ready)
        begin
            in_item_reg.raw_byte  <= track_in.raw_byte;
            in_item_reg.track_end <= track_in.track_end;
        end
    end

    ftse_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (proc),
        .item  (in_item_reg),
        .beat  (beat)
    );

    ftse_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (proc && beat.has),
        .res      (beat.res),
        .can_take (can_take),
        .tx       (sector_out)
    );

    `FTSE_ASSERT_NOW(a_nodata_is_verdict, sector_out.valid && !sector_out.byte_valid,
        sector_out.track_done, "result without data must carry the track verdict")
    `FTSE_ASSERT_NOW(a_ok_needs_done, sector_out.valid && sector_out.track_ok,
        sector_out.track_done, "track_ok raised outside end of track")
    `FTSE_ASSERT_NEXT(a_pending_kept, in_vld_reg && !proc,
        in_vld_reg, "pending raw byte dropped while stalled")
    `FTSE_ASSERT_NOW(a_stall_only_on_result, in_vld_reg && !proc,
        beat.has && !can_take, "parser stalled without a blocked result")

endmodule

`default_nettype wire

// File: sv/ftse_parser.sv
// Track parser state and one-byte step logic.
// Depends on ftse_pkg.
`default_nettype none

module ftse_parser
    import ftse_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      go,
    input  wire in_item_t  item,
    output res_beat_t      beat
);

    typedef enum logic [9:0] {
        PH_GAP   = 10'b00_0000_0001,
        PH_SYNC  = 10'b00_0000_0010,
        PH_MARK  = 10'b00_0000_0100,
        PH_ID    = 10'b00_0000_1000,
        PH_IDCRC = 10'b00_0001_0000,
        PH_GAP2  = 10'b00_0010_0000,
        PH_SYNC2 = 10'b00_0100_0000,
        PH_MARK2 = 10'b00_1000_0000,
        PH_DATA  = 10'b01_0000_0000,
        PH_DCRC  = 10'b10_0000_0000
    } phase_t;

    typedef struct packed {
        phase_t     phase;
        logic [1:0] smc;
        logic       clr_fc;
        logic       fault;
    } mark_t;

    function automatic mark_t mark_step(input logic [RAW_W-1:0] b,
                                        input logic [RAW_W-1:0] am,
                                        input phase_t cur,
                                        input phase_t ph_sync,
                                        input phase_t ph_mark,
                                        input phase_t ph_next,
                                        input logic [1:0] smc);
        mark_t r;
        r.phase  = cur;
        r.smc    = smc;
        r.clr_fc = 1'b0;
        r.fault  = 1'b0;
        priority if (b == BYTE_GAP && cur != ph_sync && cur != ph_mark)
        begin
            r.phase = cur;
        end
        else if (b == BYTE_SYNC && cur != ph_mark)
        begin
            r.phase = ph_sync;
        end
        else if (b == BYTE_MARK && smc != 2'd3)
        begin
            r.smc   = smc + 2'd1;
            r.phase = ph_mark;
        end
        else if (b == am)
        begin
            r.smc    = 2'd0;
            r.clr_fc = 1'b1;
            r.phase  = ph_next;
        end
        else
        begin
            r.fault = 1'b1;
        end
        return r;
    endfunction

    phase_t            phase_reg, phase_next;
    logic [1:0]        smc_reg, smc_next;
    logic [2:0]        fc_reg, fc_next;
    logic [LEN_W-1:0]  slen_reg, slen_next;
    logic [LEN_W-1:0]  left_reg, left_next;
    logic [OFFS_W-1:0] dest_reg, dest_next;
    logic              fault_reg, fault_next;

    logic [RAW_W-1:0]  b;
    logic              emit;
    logic              good_end;
    logic [2:0]        fc_inc;
    logic [LEN_W-1:0]  left_dec;
    mark_t             m;

    assign b        = item.raw_byte;
    assign fc_inc   = fc_reg + 3'd1;
    assign left_dec = (left_reg != '0) ? left_reg - 11'd1 : left_reg;

    always_comb
    begin
        phase_next = phase_reg;
        smc_next   = smc_reg;
        fc_next    = fc_reg;
        slen_next  = slen_reg;
        left_next  = left_reg;
        dest_next  = dest_reg;
        fault_next = fault_reg;
        emit       = 1'b0;
        good_end   = 1'b0;
        m          = mark_step(b, BYTE_IDAM, phase_reg, PH_SYNC, PH_MARK, PH_ID, smc_reg);

        if (!fault_reg)
        begin
            unique case (phase_reg)
                PH_GAP, PH_SYNC, PH_MARK:
                begin
                    good_end   = (phase_reg == PH_GAP) && (b == BYTE_GAP);
                    phase_next = m.phase;
                    smc_next   = m.smc;
                    fault_next = m.fault;
                    if (m.clr_fc)
                    begin
                        fc_next = 3'd0;
                    end
                end
                PH_ID:
                begin
                    fc_next = fc_inc;
                    if (fc_inc >= 3'd4)
                    begin
                        priority if (b == SIZE_CODE_256)
                        begin
                            slen_next = LEN_256;
                        end
                        else if (b == SIZE_CODE_512)
                        begin
                            slen_next = LEN_512;
                        end
                        else if (b == SIZE_CODE_1024)
                        begin
                            slen_next = LEN_1024;
                        end
                        else
                        begin
                            fault_next = 1'b1;
                        end
                        fc_next    = 3'd0;
                        phase_next = PH_IDCRC;
                    end
                end
                PH_IDCRC:
                begin
                    fc_next = fc_inc;
                    if (fc_inc >= 3'd2)
                    begin
                        fc_next    = 3'd0;
                        smc_next   = 2'd0;
                        phase_next = PH_GAP2;
                    end
                end
                PH_GAP2, PH_SYNC2, PH_MARK2:
                begin
                    m          = mark_step(b, BYTE_DAM, phase_reg, PH_SYNC2, PH_MARK2,
                                           PH_DATA, smc_reg);
                    phase_next = m.phase;
                    smc_next   = m.smc;
                    fault_next = m.fault;
                    if (m.clr_fc)
                    begin
                        fc_next = 3'd0;
                    end
                    if (m.phase == PH_DATA)
                    begin
                        left_next = slen_reg;
                    end
                end
                PH_DATA:
                begin
                    if (dest_reg >= DEST_BYTES)
                    begin
                        fc_next    = 3'd1;
                        phase_next = PH_DCRC;
                        good_end   = 1'b1;
                    end
                    else
                    begin
                        emit      = 1'b1;
                        dest_next = dest_reg + 13'd1;
                        left_next = left_dec;
                        if (left_dec == '0)
                        begin
                            fc_next    = 3'd0;
                            phase_next = PH_DCRC;
                        end
                    end
                end
                PH_DCRC:
                begin
                    good_end = 1'b1;
                    fc_next  = fc_inc;
                    if (fc_inc >= 3'd2)
                    begin
                        fc_next    = 3'd0;
                        smc_next   = 2'd0;
                        phase_next = PH_GAP;
                    end
                end
                default:
                begin
                    fault_next = 1'b1;
                end
            endcase
        end

        beat.has             = emit || item.track_end;
        beat.res.sector_byte = emit ? b : '0;
        beat.res.byte_valid  = emit;
        beat.res.dest_offset = emit ? dest_reg : '0;
        beat.res.track_done  = item.track_end;
        beat.res.track_ok    = item.track_end && good_end && !fault_next;

        if (item.track_end)
        begin
            phase_next = PH_GAP;
            smc_next   = 2'd0;
            fc_next    = 3'd0;
            slen_next  = '0;
            left_next  = '0;
            dest_next  = '0;
            fault_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_GAP;
            smc_reg   <= 2'd0;
            fc_reg    <= 3'd0;
            slen_reg  <= '0;
            left_reg  <= '0;
            dest_reg  <= '0;
            fault_reg <= 1'b0;
        end
        else if (go)
        begin
            phase_reg <= phase_next;
            smc_reg   <= smc_next;
            fc_reg    <= fc_next;
            slen_reg  <= slen_next;
            left_reg  <= left_next;
            dest_reg  <= dest_next;
            fault_reg <= fault_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/ftse_out_stage.sv
// Result register driving the output channel.
// Depends on ftse_pkg and ftse_out_if.
`default_nettype none

module ftse_out_stage
    import ftse_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     load,
    input  wire result_t  res,
    output logic          can_take,
    ftse_out_if.source    tx
);

    logic    vld_reg;
    result_t res_reg;

    assign can_take = !vld_reg || tx.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (load)
        begin
            vld_reg <= 1'b1;
        end
        else if (tx.ready)
        begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign tx.valid       = vld_reg;
    assign tx.sector_byte = res_reg.sector_byte;
    assign tx.byte_valid  = res_reg.byte_valid;
    assign tx.dest_offset = res_reg.dest_offset;
    assign tx.track_done  = res_reg.track_done;
    assign tx.track_ok    = res_reg.track_ok;

endmodule

`default_nettype wire

// File: verif/tb_floppy_track_sector_extractor.sv
// Testbench for floppy_track_sector_extractor: random raw tracks in, checked sector beats out.
// Depends on ftse_pkg, ftse_if and the RTL of the block; nothing else.
// An in-bench track parser predicts each result beat, compared in order.
`default_nettype none

module tb_floppy_track_sector_extractor;
    import ftse_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;

    typedef enum logic [3:0] {
        PH_GAP, PH_SYNC, PH_MARK, PH_ID, PH_IDCRC,
        PH_GAP2, PH_SYNC2, PH_MARK2, PH_DATA, PH_DCRC
    } parse_phase_t;

    typedef enum int {CLOSE_ON_GAP, CLOSE_ON_LAST, CLOSE_ON_CRC1, CLOSE_CUT} track_close_t;

    logic clk;
    logic rst_n;

    ftse_in_if  tin();
    ftse_out_if tout();

    floppy_track_sector_extractor dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .track_in   (tin),
        .sector_out (tout)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    in_item_t raw_track_q[$];
    in_item_t track_buf[$];
    result_t  sector_results_q[$];

    int  in_idle_pct  = 35;
    int  out_idle_pct = 35;
    int  err_count    = 0;
    int  results_seen = 0;
    int  shipped      = 0;
    int  stall_cnt    = 0;
    bit  in_fire      = 1'b0;

    // parser state
    parse_phase_t ph;
    logic [1:0]   marks_seen;
    logic [2:0]   fld_cnt;
    logic [10:0]  sec_len;
    logic [10:0]  sec_left;
    logic [12:0]  img_fill;
    logic         bad;

    function automatic void clear_parser();
        ph         = PH_GAP;
        marks_seen = '0;
        fld_cnt    = '0;
        sec_len    = '0;
        sec_left   = '0;
        img_fill   = '0;
        bad        = 1'b0;
    endfunction

    function automatic void hunt_mark(input logic [7:0] b, input logic [7:0] am,
                                      input parse_phase_t ph_sync, input parse_phase_t ph_mark,
                                      input parse_phase_t ph_next);
        if (b == BYTE_GAP && ph != ph_sync && ph != ph_mark)
            return;
        if (b == BYTE_SYNC && ph != ph_mark)
        begin
            ph = ph_sync;
            return;
        end
        if (b == BYTE_MARK && marks_seen < 2'd3)
        begin
            marks_seen = marks_seen + 2'd1;
            ph = ph_mark;
            return;
        end
        if (b == am)
        begin
            marks_seen = '0;
            fld_cnt = '0;
            ph = ph_next;
            return;
        end
        bad = 1'b1;
    endfunction

    function automatic bit parse_raw_byte(input in_item_t it, output result_t r);
        logic [7:0] b;
        bit         emit;
        bit         good_end;
        b        = it.raw_byte;
        emit     = 1'b0;
        good_end = 1'b0;
        r        = '0;
        if (!bad)
        begin
            case (ph)
                PH_GAP, PH_SYNC, PH_MARK:
                begin
                    if (ph == PH_GAP && b == BYTE_GAP)
                        good_end = 1'b1;
                    hunt_mark(b, BYTE_IDAM, PH_SYNC, PH_MARK, PH_ID);
                end
                PH_ID:
                begin
                    fld_cnt = fld_cnt + 3'd1;
                    if (fld_cnt >= 3'd4)
                    begin
                        if (b == SIZE_CODE_256)
                            sec_len = LEN_256;
                        else if (b == SIZE_CODE_512)
                            sec_len = LEN_512;
                        else if (b == SIZE_CODE_1024)
                            sec_len = LEN_1024;
                        else
                            bad = 1'b1;
                        fld_cnt = '0;
                        ph = PH_IDCRC;
                    end
                end
                PH_IDCRC:
                begin
                    fld_cnt = fld_cnt + 3'd1;
                    if (fld_cnt >= 3'd2)
                    begin
                        fld_cnt = '0;
                        marks_seen = '0;
                        ph = PH_GAP2;
                    end
                end
                PH_GAP2, PH_SYNC2, PH_MARK2:
                begin
                    hunt_mark(b, BYTE_DAM, PH_SYNC2, PH_MARK2, PH_DATA);
                    if (ph == PH_DATA)
                        sec_left = sec_len;
                end
                PH_DATA:
                begin
                    if (img_fill >= DEST_BYTES)
                    begin
                        // image full: byte counts as first data CRC byte
                        fld_cnt = 3'd1;
                        ph = PH_DCRC;
                        good_end = 1'b1;
                    end
                    else
                    begin
                        emit = 1'b1;
                        r.sector_byte = b;
                        r.byte_valid  = 1'b1;
                        r.dest_offset = img_fill;
                        img_fill = img_fill + 13'd1;
                        if (sec_left > 0)
                            sec_left = sec_left - 11'd1;
                        if (sec_left == 0)
                        begin
                            fld_cnt = '0;
                            ph = PH_DCRC;
                        end
                    end
                end
                PH_DCRC:
                begin
                    good_end = 1'b1;
                    fld_cnt = fld_cnt + 3'd1;
                    if (fld_cnt >= 3'd2)
                    begin
                        fld_cnt = '0;
                        marks_seen = '0;
                        ph = PH_GAP;
                    end
                end
                default:
                    bad = 1'b1;
            endcase
        end
        r.track_done = it.track_end;
        r.track_ok   = it.track_end && good_end && !bad;
        if (it.track_end)
            clear_parser();
        return emit || it.track_end;
    endfunction

    function automatic void check_field(input string name, input logic [12:0] want,
                                        input logic [12:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            err_count++;
        end
    endfunction

    // ---------------- stimulus building ----------------

    task automatic put_raw(input logic [7:0] b);
        in_item_t it;
        it.raw_byte  = b;
        it.track_end = 1'b0;
        track_buf.push_back(it);
    endtask

    task automatic put_mark_run(input logic [7:0] am, input bit four_marks);
        int n_mark;
        n_mark = four_marks ? 4 : $urandom_range(0, 3);
        repeat ($urandom_range(0, 4)) put_raw(BYTE_GAP);
        repeat ($urandom_range(0, 3)) put_raw(BYTE_SYNC);
        repeat (n_mark) put_raw(BYTE_MARK);
        put_raw(am);
    endtask

    task automatic put_header(input logic [7:0] code, input bit four_marks);
        put_mark_run(BYTE_IDAM, four_marks);
        repeat (3) put_raw(8'($urandom_range(0, 255)));
        put_raw(code);
        repeat (2) put_raw(8'($urandom_range(0, 255)));
    endtask

    task automatic put_sector(input logic [7:0] code, input bit four_marks);
        int n_data;
        put_header(code, four_marks);
        put_mark_run(BYTE_DAM, 1'b0);
        if (code == SIZE_CODE_256)
            n_data = 256;
        else if (code == SIZE_CODE_512)
            n_data = 512;
        else if (code == SIZE_CODE_1024)
            n_data = 1024;
        else
            n_data = 16;
        repeat (n_data) put_raw(8'($urandom_range(0, 255)));
        repeat (2) put_raw(8'($urandom_range(0, 255)));
    endtask

    task automatic ship_track(input track_close_t how);
        in_item_t it;
        int       cut;
        case (how)
            CLOSE_ON_GAP:
                put_raw(BYTE_GAP);
            CLOSE_ON_CRC1:
                if (track_buf.size() > 1)
                    it = track_buf.pop_back();
            CLOSE_CUT:
                if (track_buf.size() > 1)
                begin
                    cut = $urandom_range(0, track_buf.size() - 1);
                    while (track_buf.size() > cut + 1)
                        it = track_buf.pop_back();
                end
            default:
                ;
        endcase
        if (track_buf.size() == 0)
            put_raw(BYTE_GAP);
        it = track_buf.pop_back();
        it.track_end = 1'b1;
        track_buf.push_back(it);
        foreach (track_buf[i])
            raw_track_q.push_back(track_buf[i]);
        shipped += track_buf.size();
        track_buf.delete();
    endtask

    task automatic random_track();
        int         kind;
        int         roll;
        int         idx;
        logic [7:0] code;
        in_item_t   it;
        kind = $urandom_range(0, 99);
        if (kind < 6)
            repeat ($urandom_range(1, 30)) put_raw(8'($urandom_range(0, 255)));
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 80)
                code = SIZE_CODE_256;
            else if (roll < 90)
                code = SIZE_CODE_512;
            else if (roll < 95)
                code = SIZE_CODE_1024;
            else
                code = 8'($urandom_range(0, 255));
            if (kind < 45)
            begin
                put_header(code, $urandom_range(0, 99) < 5);
                if ($urandom_range(0, 1))
                    put_mark_run(BYTE_DAM, 1'b0);
            end
            else
                repeat ($urandom_range(1, 2)) put_sector(code, $urandom_range(0, 99) < 4);
            if (kind >= 90)
            begin
                idx = $urandom_range(0, track_buf.size() - 1);
                it = track_buf[idx];
                it.raw_byte = 8'($urandom_range(0, 255));
                track_buf[idx] = it;
            end
        end
        ship_track(track_close_t'($urandom_range(0, 3)));
    endtask

    task automatic wait_quiet();
        while (raw_track_q.size() != 0 || tin.valid || sector_results_q.size() != 0)
            @(posedge clk);
    endtask

    // ---------------- driver ----------------

    always @(negedge clk)
    begin
        in_item_t nxt;
        if (!rst_n)
            tin.valid <= 1'b0;
        else if (!tin.valid || in_fire)
        begin
            if (raw_track_q.size() != 0 && $urandom_range(0, 99) >= in_idle_pct)
            begin
                nxt = raw_track_q.pop_front();
                tin.valid     <= 1'b1;
                tin.raw_byte  <= nxt.raw_byte;
                tin.track_end <= nxt.track_end;
            end
            else
                tin.valid <= 1'b0;
        end
    end

    // ---------------- receiver ready ----------------

    int hold_left    = 0;
    int next_hold_at = 200;

    always @(negedge clk)
    begin
        if (!rst_n)
            tout.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            tout.ready <= 1'b0;
        end
        else if (results_seen >= next_hold_at)
        begin
            hold_left = HOLD_CYCLES;
            next_hold_at = (next_hold_at == 200) ? 3000 : 32'h7fff_ffff;
            tout.ready <= 1'b0;
        end
        else
            tout.ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end

    // ---------------- monitor, prediction, watchdog ----------------

    always @(posedge clk)
    begin
        in_item_t acc;
        result_t  want;
        bit       out_fire;
        if (rst_n)
        begin
            in_fire  = tin.valid && tin.ready;
            out_fire = tout.valid && tout.ready;
            if (in_fire)
            begin
                acc.raw_byte  = tin.raw_byte;
                acc.track_end = tin.track_end;
                if (parse_raw_byte(acc, want))
                    sector_results_q.push_back(want);
            end
            if (out_fire)
            begin
                results_seen++;
                if (sector_results_q.size() == 0)
                begin
                    $display("%0t: unexpected beat, expected none actual byte %0h valid %0b",
                             $time, tout.sector_byte, tout.byte_valid);
                    $display("    offset %0d done %0b ok %0b",
                             tout.dest_offset, tout.track_done, tout.track_ok);
                    err_count++;
                end
                else
                begin
                    want = sector_results_q.pop_front();
                    check_field("sector_byte", 13'(want.sector_byte), 13'(tout.sector_byte));
                    check_field("byte_valid", 13'(want.byte_valid), 13'(tout.byte_valid));
                    check_field("dest_offset", want.dest_offset, tout.dest_offset);
                    check_field("track_done", 13'(want.track_done), 13'(tout.track_done));
                    check_field("track_ok", 13'(want.track_ok), 13'(tout.track_ok));
                end
            end
            if (in_fire || out_fire)
                stall_cnt = 0;
            else
                stall_cnt++;
            if (stall_cnt >= STALL_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // ---------------- sequence ----------------

    initial
    begin
        rst_n          = 1'b0;
        tin.valid      = 1'b0;
        tin.raw_byte   = '0;
        tin.track_end  = 1'b0;
        tout.ready     = 1'b0;
        clear_parser();

        // short directed tracks
        put_raw(BYTE_GAP);
        ship_track(CLOSE_ON_LAST);
        put_raw(BYTE_SYNC);
        ship_track(CLOSE_ON_LAST);
        put_raw(BYTE_SYNC);
        ship_track(CLOSE_ON_GAP);
        repeat (4) put_raw(BYTE_MARK);
        put_raw(BYTE_IDAM);
        ship_track(CLOSE_ON_LAST);
        put_raw(BYTE_IDAM);
        repeat (3) put_raw(8'h00);
        put_raw(8'hFF);
        ship_track(CLOSE_ON_GAP);
        put_raw(BYTE_IDAM);
        repeat (3) put_raw(8'hFF);
        put_raw(8'h00);
        ship_track(CLOSE_ON_GAP);
        put_raw(BYTE_IDAM);
        put_raw(8'h01);
        put_raw(8'h02);
        put_raw(8'h03);
        put_raw(SIZE_CODE_256);
        put_raw(8'hAA);
        ship_track(CLOSE_ON_LAST);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait_quiet();

        shipped = 0;
        while (shipped < 400)
            random_track();
        wait_quiet();

        // stretch with no idling on either side
        in_idle_pct  = 0;
        out_idle_pct = 0;
        while (shipped < 700)
            random_track();
        wait_quiet();
        in_idle_pct  = 35;
        out_idle_pct = 35;

        while (shipped < 1000)
            random_track();
        wait_quiet();

        repeat (20) @(posedge clk);
        if (sector_results_q.size() != 0)
        begin
            $display("%0t: %0d expected beats never arrived", $time, sector_results_q.size());
            err_count++;
        end
        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

// File: floppy_track_sector_extractor.f
+incdir+sv
sv/ftse_pkg.sv
sv/ftse_if.sv
sv/ftse_parser.sv
sv/ftse_out_stage.sv
sv/floppy_track_sector_extractor.sv
verif/tb_floppy_track_sector_extractor.sv
